// ===== sv/gpm_pkg.sv =====
// Shared constants, types and helpers for the glob path matcher.
package gpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_PATH   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QMARK    = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH   = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic              restart;
        logic              consume;
        logic              wr_en;
        logic [CHAR_W-1:0] wr_char;
        logic [CHAR_W-1:0] path_char;
        logic              path_slash;
        logic              case_sens;
        logic [LEN_W-1:0]  length;
    } t_cell_ctl;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } t_rsp;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic case_sens);
        if (!case_sens && c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// ===== sv/gpm_req_if.sv =====
// Request channel: operation and character with valid/ready.
interface gpm_req_if;
    logic                        valid;
    logic                        ready;
    logic [gpm_pkg::OP_W-1:0]    operation;
    logic [gpm_pkg::CHAR_W-1:0]  character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

// ===== sv/gpm_rsp_if.sv =====
// Response channel: match result and overflow flag with valid/ready.
interface gpm_rsp_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== sv/gpm_cell.sv =====
// One pattern position: stored character, active bit and star carry.
module gpm_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gpm_pkg::IDX_W-1:0]  i_index,
    input  gpm_pkg::t_cell_ctl         i_ctl,
    input  logic                       i_reach,
    input  logic                       i_fwd,
    input  logic                       i_next_star,
    output logic                       o_reach,
    output logic                       o_fwd,
    output logic                       o_star,
    output logic                       o_final,
    output logic                       o_active
);

    logic [gpm_pkg::CHAR_W-1:0] r_char;
    logic                       r_active;
    logic                       n_active;
    logic [gpm_pkg::LEN_W-1:0]  w_pos;
    logic                       w_valid;
    logic                       w_end;
    logic                       w_star;
    logic                       w_exp;
    logic                       w_hit;
    logic                       w_keep;

    assign w_pos   = gpm_pkg::LEN_W'(i_index);
    assign w_valid = w_pos < i_ctl.length;
    assign w_end   = w_pos == i_ctl.length;
    assign w_star  = w_valid && (r_char == gpm_pkg::CH_STAR);
    // star run ending just before this position lets the path skip to here
    assign w_exp   = r_active | (i_reach & ~w_star);
    assign w_hit   = (r_char == gpm_pkg::CH_QMARK) ||
                     (gpm_pkg::fold_char(r_char, i_ctl.case_sens) == i_ctl.path_char);
    // a lone star stops at a separator; a double star crosses it
    assign w_keep  = w_star & r_active & (i_next_star | ~i_ctl.path_slash);

    assign o_reach  = w_star & (r_active | i_reach);
    assign o_fwd    = w_valid & ~w_star & w_exp & w_hit;
    assign o_star   = w_star;
    assign o_final  = w_exp & w_end;
    assign o_active = r_active;

    always_comb begin
        n_active = r_active;
        if (i_ctl.restart) begin
            n_active = (i_index == '0);
        end else if (i_ctl.consume) begin
            n_active = w_keep | i_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= (i_index == '0);
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && w_end) begin
            r_char <= i_ctl.wr_char;
        end
    end

endmodule

// ===== sv/gpm_rsp_buf.sv =====
// Two-slot response buffer: output register plus skid slot.
module gpm_rsp_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpm_pkg::t_rsp     i_data,
    output logic              o_ready,
    gpm_rsp_if.source         o_rsp
);

    logic          r_out_valid;
    logic          n_out_valid;
    gpm_pkg::t_rsp r_out;
    gpm_pkg::t_rsp n_out;
    logic          r_skid_valid;
    logic          n_skid_valid;
    gpm_pkg::t_rsp r_skid;
    gpm_pkg::t_rsp n_skid;
    logic          w_pop;

    assign w_pop   = r_out_valid & o_rsp.ready;
    assign o_ready = ~r_skid_valid;

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.matched          = r_out.matched;
    assign o_rsp.pattern_overflow = r_out.pattern_overflow;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out       = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("response pushed into full buffer");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds data with output slot empty");

endmodule

// ===== sv/glob_path_matcher_core.sv =====
// Glob path matcher top level: control, row of position cells, response buffer.
//
// Usage:
//   i_req carries one request per handshake: operation 0 clears the pattern,
//   1 appends a pattern character, 2 streams a path character, 3 ends the
//   path. Only operation 3 yields a response on o_rsp (matched and
//   pattern_overflow). Backslashes count as '/'.
//   i_cfg_wr_en/i_cfg_wr_data select exact-case compare (1) or ASCII case
//   folding (0); write only while idle.
// Throughput: one request per cycle while i_req.ready is high. Every position cell updates in the
//   same cycle; the star-run carry rippling along the cell row sets the
//   critical path.
// Response: the end-of-path result is registered in the response buffer
//   and is shown on o_rsp from there.
// Reset: pattern empty, overflow clear, exact-case compare, only position
//   zero active.
// Stall: responses queue in a two-slot buffer; i_req.ready drops only while
//   both slots are full, and recovers the cycle after o_rsp is taken.
module glob_path_matcher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    gpm_req_if.sink     i_req,
    gpm_rsp_if.source   o_rsp
);

    logic [gpm_pkg::LEN_W-1:0]    r_len;
    logic [gpm_pkg::LEN_W-1:0]    n_len;
    logic                         r_has_sep;
    logic                         n_has_sep;
    logic                         r_ovf;
    logic                         n_ovf;
    logic                         r_cs;
    logic                         r_a_last;
    logic                         n_a_last;
    logic                         w_acc;
    logic                         w_push;
    logic                         w_buf_ready;
    gpm_pkg::t_op                 w_op;
    logic [gpm_pkg::CHAR_W-1:0]   w_char;
    gpm_pkg::t_cell_ctl           w_ctl;
    gpm_pkg::t_rsp                w_rsp;
    logic [gpm_pkg::MAX_PATTERN:0] w_reach;
    logic [gpm_pkg::MAX_PATTERN:0] w_fwd;
    logic [gpm_pkg::MAX_PATTERN:0] w_star;
    logic [gpm_pkg::MAX_PATTERN:0] w_final;
    logic [gpm_pkg::MAX_PATTERN:0] w_active;

    assign w_acc       = i_req.valid & i_req.ready;
    assign i_req.ready = w_buf_ready;
    assign w_op        = gpm_pkg::t_op'(i_req.operation);
    assign w_char      = (i_req.character == gpm_pkg::CH_BSLASH) ? gpm_pkg::CH_SLASH
                                                                 : i_req.character;

    always_comb begin
        n_len           = r_len;
        n_has_sep       = r_has_sep;
        n_ovf           = r_ovf;
        w_push          = 1'b0;
        w_ctl.restart   = 1'b0;
        w_ctl.consume   = 1'b0;
        w_ctl.wr_en     = 1'b0;
        w_ctl.wr_char   = w_char;
        w_ctl.path_char = gpm_pkg::fold_char(w_char, r_cs);
        w_ctl.path_slash = (w_char == gpm_pkg::CH_SLASH);
        w_ctl.case_sens = r_cs;
        w_ctl.length    = r_len;
        if (w_acc) begin
            unique case (w_op)
                gpm_pkg::OP_CLEAR: begin
                    n_len         = '0;
                    n_has_sep     = 1'b0;
                    n_ovf         = 1'b0;
                    w_ctl.restart = 1'b1;
                end
                gpm_pkg::OP_APPEND: begin
                    if (r_len < gpm_pkg::LEN_W'(gpm_pkg::MAX_PATTERN)) begin
                        w_ctl.wr_en = 1'b1;
                        n_len       = r_len + gpm_pkg::LEN_W'(1);
                        n_has_sep   = r_has_sep | w_ctl.path_slash;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    w_ctl.restart = 1'b1;
                end
                gpm_pkg::OP_PATH: begin
                    // without a separator in the pattern, each '/' restarts
                    if (w_ctl.path_slash && !r_has_sep) begin
                        w_ctl.restart = 1'b1;
                    end else begin
                        w_ctl.consume = 1'b1;
                    end
                end
                gpm_pkg::OP_END: begin
                    w_push        = 1'b1;
                    w_ctl.restart = 1'b1;
                end
            endcase
        end
    end

    assign w_reach[0]                    = 1'b0;
    assign w_fwd[0]                      = 1'b0;
    assign w_star[gpm_pkg::MAX_PATTERN]  = 1'b0;

    for (genvar g = 0; g < gpm_pkg::MAX_PATTERN; g++) begin : g_cell
        gpm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (gpm_pkg::IDX_W'(g)),
            .i_ctl       (w_ctl),
            .i_reach     (w_reach[g]),
            .i_fwd       (w_fwd[g]),
            .i_next_star (w_star[g+1]),
            .o_reach     (w_reach[g+1]),
            .o_fwd       (w_fwd[g+1]),
            .o_star      (w_star[g]),
            .o_final     (w_final[g]),
            .o_active    (w_active[g])
        );
    end

    // position past the last storable character
    assign w_final[gpm_pkg::MAX_PATTERN]  = (r_a_last | w_reach[gpm_pkg::MAX_PATTERN]) &
                                            (r_len == gpm_pkg::LEN_W'(gpm_pkg::MAX_PATTERN));
    assign w_active[gpm_pkg::MAX_PATTERN] = r_a_last;

    always_comb begin
        n_a_last = r_a_last;
        if (w_ctl.restart) begin
            n_a_last = 1'b0;
        end else if (w_ctl.consume) begin
            n_a_last = w_fwd[gpm_pkg::MAX_PATTERN];
        end
    end

    assign w_rsp.matched          = |w_final;
    assign w_rsp.pattern_overflow = r_ovf;

    gpm_rsp_buf u_rsp_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_rsp),
        .o_ready (w_buf_ready),
        .o_rsp   (o_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_has_sep <= 1'b0;
            r_ovf     <= 1'b0;
            r_cs      <= 1'b1;
            r_a_last  <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_has_sep <= n_has_sep;
            r_ovf     <= n_ovf;
            r_a_last  <= n_a_last;
            if (i_cfg_wr_en) begin
                r_cs <= i_cfg_wr_data;
            end
        end
    end

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= gpm_pkg::LEN_W'(gpm_pkg::MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_clear_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == gpm_pkg::OP_CLEAR) |=> (r_len == '0 && !r_ovf && !r_has_sep))
        else $error("clear request left pattern state behind");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == gpm_pkg::OP_END) |=> (w_active[0] && $onehot(w_active)))
        else $error("active set not back at position zero after path end");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(w_acc && w_op == gpm_pkg::OP_CLEAR)) |=> r_ovf)
        else $error("overflow flag dropped without clear");

endmodule
